// ----- hw/rtl/dbcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth background capture/remove package
// Shared types and constants for the background capture and removal unit.
// ----------------------------------------------------------------------------
package dbcr_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 524288;
  localparam int unsigned IDX_W          = 20;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned PADDR_W        = 4;

  localparam logic [10:0] WIDTH_MAX  = 11'd1024;
  localparam logic [9:0]  HEIGHT_MAX = 10'd512;

  localparam logic [10:0] WIDTH_RST   = 11'd640;
  localparam logic [9:0]  HEIGHT_RST  = 10'd480;
  localparam logic [15:0] INVALID_RST = 16'd2047;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_INVALID_VALUE = 2'd2;
  localparam logic [1:0] REG_REMOVE_ENABLE = 2'd3;

  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_CAPTURE = 1'b1;

  localparam logic [1:0] OP_FILL   = 2'd0;
  localparam logic [1:0] OP_MIN    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_PASS   = 2'd3;

  typedef struct packed {
    logic        func;
    logic [15:0] depth_in;
    logic [15:0] frame_count;
  } dbcr_in_t;

  typedef struct packed {
    logic [15:0] depth_out;
    logic        frame_last;
  } dbcr_out_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [9:0]  frame_height;
    logic [15:0] invalid_value;
    logic        remove_enable;
  } dbcr_cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [15:0]      depth;
    logic [15:0]      inv;
    logic             last;
  } dbcr_op_t;

endpackage

// ----- hw/rtl/dbcr_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding frame size, invalid code and removal enable.
// ----------------------------------------------------------------------------
module dbcr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dbcr_pkg::dbcr_cfg_t         cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[dbcr_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= dbcr_pkg::WIDTH_RST;
      cfg.frame_height  <= dbcr_pkg::HEIGHT_RST;
      cfg.invalid_value <= dbcr_pkg::INVALID_RST;
      cfg.remove_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        dbcr_pkg::REG_FRAME_WIDTH:   cfg.frame_width   <= pwdata[10:0];
        dbcr_pkg::REG_FRAME_HEIGHT:  cfg.frame_height  <= pwdata[9:0];
        dbcr_pkg::REG_INVALID_VALUE: cfg.invalid_value <= pwdata[15:0];
        dbcr_pkg::REG_REMOVE_ENABLE: cfg.remove_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dbcr_pkg::REG_FRAME_WIDTH:   prdata = {21'd0, cfg.frame_width};
      dbcr_pkg::REG_FRAME_HEIGHT:  prdata = {22'd0, cfg.frame_height};
      dbcr_pkg::REG_INVALID_VALUE: prdata = {16'd0, cfg.invalid_value};
      dbcr_pkg::REG_REMOVE_ENABLE: prdata = {31'd0, cfg.remove_enable};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/dbcr_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Tracks the raster position and capture state and classifies each beat.
// ----------------------------------------------------------------------------
module dbcr_front #(
  parameter int unsigned MAX_PIXELS = dbcr_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dbcr_pkg::dbcr_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  dbcr_pkg::dbcr_in_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output dbcr_pkg::dbcr_op_t  q_entry
);

  logic [15:0] frames_left;
  logic        store_present;
  logic [9:0]  column_pos;
  logic [8:0]  row_pos;

  logic [10:0] w;
  logic [9:0]  h;
  logic        row_end;
  logic        last;
  logic [dbcr_pkg::IDX_W-1:0] idx;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    if (cfg.frame_width == 11'd0) begin
      w = 11'd1;
    end else if (cfg.frame_width > dbcr_pkg::WIDTH_MAX) begin
      w = dbcr_pkg::WIDTH_MAX;
    end else begin
      w = cfg.frame_width;
    end
    if (cfg.frame_height == 10'd0) begin
      h = 10'd1;
    end else if (cfg.frame_height > dbcr_pkg::HEIGHT_MAX) begin
      h = dbcr_pkg::HEIGHT_MAX;
    end else begin
      h = cfg.frame_height;
    end
  end

  assign row_end = ({1'b0, column_pos} + 11'd1) >= w;
  assign last    = row_end && (({1'b0, row_pos} + 10'd1) >= h);
  assign idx     = dbcr_pkg::IDX_W'(row_pos) * dbcr_pkg::IDX_W'(w)
                 + dbcr_pkg::IDX_W'(column_pos);

  always_comb begin
    q_entry.depth    = in_data.depth_in;
    q_entry.inv      = cfg.invalid_value;
    q_entry.idx      = idx;
    q_entry.in_range = {1'b0, idx} < 21'(MAX_PIXELS);
    q_entry.last     = last;
    if (in_data.func == dbcr_pkg::FUNC_CAPTURE) begin
      q_entry.op = dbcr_pkg::OP_FILL;
    end else if (frames_left != 16'd0) begin
      q_entry.op = dbcr_pkg::OP_MIN;
    end else if (cfg.remove_enable && store_present) begin
      q_entry.op = dbcr_pkg::OP_REMOVE;
    end else begin
      q_entry.op = dbcr_pkg::OP_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_left   <= 16'd0;
      store_present <= 1'b0;
      column_pos    <= 10'd0;
      row_pos       <= 9'd0;
    end else if (accept) begin
      if (in_data.func == dbcr_pkg::FUNC_CAPTURE) begin
        frames_left   <= in_data.frame_count;
        store_present <= 1'b1;
        column_pos    <= 10'd0;
        row_pos       <= 9'd0;
      end else begin
        if (frames_left != 16'd0 && last) begin
          frames_left <= frames_left - 16'd1;
        end
        if (row_end) begin
          column_pos <= 10'd0;
          row_pos    <= last ? 9'd0 : row_pos + 9'd1;
        end else begin
          column_pos <= column_pos + 10'd1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dbcr_queue.sv -----
// ----------------------------------------------------------------------------
// Operation queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module dbcr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dbcr_pkg::dbcr_op_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output dbcr_pkg::dbcr_op_t head
);

  localparam int unsigned PTR_W = $clog2(dbcr_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  dbcr_pkg::dbcr_op_t entries [dbcr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(dbcr_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/dbcr_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Owns the background store: fills it on capture, updates or compares it for
// each pixel and drives the registered output beat.
// ----------------------------------------------------------------------------
module dbcr_back #(
  parameter int unsigned MAX_PIXELS = dbcr_pkg::MAX_PIXELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  dbcr_pkg::dbcr_op_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output dbcr_pkg::dbcr_out_t out_data
);

  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [15:0] mem [MAX_PIXELS];

  logic               b_valid;
  dbcr_pkg::dbcr_op_t b_op;
  logic [15:0]        rdata;

  logic              last_wr_valid;
  logic [ADDR_W-1:0] last_wr_addr;
  logic [15:0]       last_wr_data;

  logic              sweep_active;
  logic [ADDR_W-1:0] sweep_cnt;

  logic              head_fill;
  logic              b_fire;
  logic              start_sweep;
  logic              sweep_done;
  logic              pop_pixel;
  logic [ADDR_W-1:0] b_addr;
  logic [15:0]       bg;
  logic              min_wr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic [15:0]       result;

  assign head_fill   = head.op == dbcr_pkg::OP_FILL;
  assign b_fire      = b_valid && (!out_valid || !out_stall);
  assign start_sweep = head_valid && head_fill && !b_valid && !sweep_active;
  assign sweep_done  = sweep_active && (sweep_cnt == ADDR_W'(MAX_PIXELS - 1));
  assign pop_pixel   = head_valid && !head_fill && (!b_valid || b_fire);
  assign pop         = pop_pixel || sweep_done;

  assign b_addr = b_op.idx[ADDR_W-1:0];
  assign bg     = (last_wr_valid && last_wr_addr == b_addr) ? last_wr_data : rdata;
  assign min_wr = b_fire && b_op.op == dbcr_pkg::OP_MIN && b_op.in_range && bg > b_op.depth;

  always_comb begin
    if (sweep_active) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
      wr_data = head.inv;
    end else begin
      wr_en   = min_wr;
      wr_addr = b_addr;
      wr_data = b_op.depth;
    end
  end

  always_comb begin
    if (b_op.op == dbcr_pkg::OP_REMOVE && b_op.in_range && b_op.depth >= bg) begin
      result = b_op.inv;
    end else begin
      result = b_op.depth;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (pop_pixel) begin
      rdata <= mem[head.idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      b_op <= head;
    end
    if (wr_en) begin
      last_wr_addr <= wr_addr;
      last_wr_data <= wr_data;
    end
    if (!out_valid || !out_stall) begin
      out_data.depth_out  <= result;
      out_data.frame_last <= b_op.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid       <= 1'b0;
      last_wr_valid <= 1'b0;
      sweep_active  <= 1'b0;
      sweep_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop_pixel) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (wr_en) begin
        last_wr_valid <= 1'b1;
      end
      if (start_sweep) begin
        sweep_active <= 1'b1;
        sweep_cnt    <= '0;
      end else if (sweep_done) begin
        sweep_active <= 1'b0;
      end else if (sweep_active) begin
        sweep_cnt <= sweep_cnt + ADDR_W'(1);
      end
      if (!out_valid || !out_stall) begin
        out_valid <= b_valid;
      end
    end
  end

endmodule

// ----- hw/rtl/depth_background_capture_remove_unit.sv -----
// ----------------------------------------------------------------------------
// Depth background capture and removal unit
// Captures a per-pixel minimum depth background over a number of frames and
// then replaces pixels at or beyond that background with the invalid code.
//
//   Channel   Direction  Handshake            Beat
//   in        input      in_valid / in_stall  dbcr_in_t (command or pixel)
//   out       output     out_valid/out_stall  dbcr_out_t (one per pixel)
//   apb       input      psel/penable/pready  32-bit register write or read
//
// Pixels are taken one per clock while the queue is not full and pass through
// the queue, the store read register and the output register. A capture
// command makes the back end fill the store while the front end goes on
// taking beats until the queue is full. The rate is set by the single read and
// single write port of the store. Reset is synchronous; the store itself is
// not cleared by reset. Output stalls back up through the queue to in_stall.
// ----------------------------------------------------------------------------
module depth_background_capture_remove_unit #(
  parameter int unsigned MAX_PIXELS = dbcr_pkg::MAX_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dbcr_pkg::dbcr_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dbcr_pkg::dbcr_out_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dbcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  dbcr_pkg::dbcr_cfg_t cfg;
  dbcr_pkg::dbcr_op_t  push_entry;
  dbcr_pkg::dbcr_op_t  head;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                head_valid;

  dbcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dbcr_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  dbcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dbcr_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
